/* design/svf_pkg.sv */
// Shared types, widths and helper functions for the state variable filter.
`timescale 1ns / 1ps
package svf_pkg;

   localparam int SAMPLE_W  = 24;
   localparam int COEF_W    = 24;
   localparam int COEF_FRAC = 22;
   localparam int INT_W     = 32;
   localparam int WIDE_W    = 38;               // v1, v2, v3, k*v1
   localparam int OPA_W     = COEF_W + 1;       // coefficient with a zero sign bit
   localparam int PROD_W    = OPA_W + WIDE_W;
   localparam int ACC_W     = 64;
   localparam int SUM_W     = WIDE_W + 3;       // integrator update and response sums
   localparam int MODE_W    = 3;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MODE    = 3'd0,
      REG_COEF_A1 = 3'd1,
      REG_COEF_A2 = 3'd2,
      REG_COEF_A3 = 3'd3,
      REG_DAMPING = 3'd4
   } reg_index_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOWPASS  = 3'd0,
      MODE_BANDPASS = 3'd1,
      MODE_HIGHPASS = 3'd2,
      MODE_NOTCH    = 3'd3,
      MODE_PEAK     = 3'd4
   } mode_type;

   localparam logic [MODE_W-1:0] MODE_RESET    = MODE_W'(MODE_LOWPASS);
   localparam logic [COEF_W-1:0] COEF_A1_RESET = COEF_W'(1) << COEF_FRAC;
   localparam logic [COEF_W-1:0] COEF_A2_RESET = '0;
   localparam logic [COEF_W-1:0] COEF_A3_RESET = '0;
   localparam logic [COEF_W-1:0] DAMPING_RESET = COEF_W'(1) << COEF_FRAC;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [COEF_W-1:0] coef_a1;
      logic [COEF_W-1:0] coef_a2;
      logic [COEF_W-1:0] coef_a3;
      logic [COEF_W-1:0] damping;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROD_A1,
      ST_PROD_A2V3,
      ST_PROD_A2IC1,
      ST_PROD_A3V3,
      ST_PROD_KV1,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      MUL_A1_IC1,
      MUL_A2_V3,
      MUL_A2_IC1,
      MUL_A3_V3,
      MUL_K_V1
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef struct packed {
      logic        load_x;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        cap_v1;
      logic        upd_int;
      logic        load_out;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   // Clamp a wide sum to the integrator range.
   function automatic logic [INT_W-1:0] sat_int(input logic [SUM_W-1:0] v);
      logic [SUM_W-INT_W:0] top;
      top = v[SUM_W-1:INT_W-1];
      if ((&top) || !(|top)) begin
         sat_int = v[INT_W-1:0];
      end else if (v[SUM_W-1]) begin
         sat_int = {1'b1, {(INT_W-1){1'b0}}};
      end else begin
         sat_int = {1'b0, {(INT_W-1){1'b1}}};
      end
   endfunction

   // Clamp a wide sum to the sample range.
   function automatic logic [SAMPLE_W-1:0] sat_sample(input logic [SUM_W-1:0] v);
      logic [SUM_W-SAMPLE_W:0] top;
      top = v[SUM_W-1:SAMPLE_W-1];
      if ((&top) || !(|top)) begin
         sat_sample = v[SAMPLE_W-1:0];
      end else if (v[SUM_W-1]) begin
         sat_sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         sat_sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   endfunction

endpackage

/* design/state_variable_filter_core.sv */
// Top level of the trapezoidal state variable filter.
`timescale 1ns / 1ps
// Trapezoidal state variable filter for signed 24-bit samples. One sample holds the
// sequencer from its acceptance until its result is loaded into the output
// register. One 25 x 38 bit multiplier is shared by the five coefficient
// products (a1*ic1, a2*v3, a2*ic1, a3*v3, k*v1). Each product is registered and
// summed in one accumulator, so the sequencer visits one state per product plus
// acceptance, integrator update and output load. The result sits in an output
// register. The next sample is taken while it waits, and the sequencer holds only
// if a new result is ready before the old one has gone. Write the mode and
// coefficient registers while no sample is in flight. A write to an index past the
// damping register is dropped.
module state_variable_filter_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [svf_pkg::SAMPLE_W-1:0]  req_sample_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [svf_pkg::SAMPLE_W-1:0]  rsp_sample_out,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [svf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [svf_pkg::COEF_W-1:0]    csr_data
);
   import svf_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   svf_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   svf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   svf_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (cmd),
      .status         (status),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule

/* design/svf_regs.sv */
// Configuration register bank: mode, coefficients and damping.
`timescale 1ns / 1ps
module svf_regs (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [svf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [svf_pkg::COEF_W-1:0]     csr_data,
   output svf_pkg::cfg_type               cfg
);
   import svf_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         // indexes past the last register drop the beat
         unique case (reg_index_type'(csr_index))
            REG_MODE:    cfg_in.mode    = csr_data[MODE_W-1:0];
            REG_COEF_A1: cfg_in.coef_a1 = csr_data;
            REG_COEF_A2: cfg_in.coef_a2 = csr_data;
            REG_COEF_A3: cfg_in.coef_a3 = csr_data;
            REG_DAMPING: cfg_in.damping = csr_data;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode    <= MODE_RESET;
         cfg_ff.coef_a1 <= COEF_A1_RESET;
         cfg_ff.coef_a2 <= COEF_A2_RESET;
         cfg_ff.coef_a3 <= COEF_A3_RESET;
         cfg_ff.damping <= DAMPING_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* design/svf_ctrl.sv */
// Sequencer that steps one sample through the shared multiplier.
`timescale 1ns / 1ps
module svf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  svf_pkg::status_type  status,
   output svf_pkg::cmd_type     cmd
);
   import svf_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd.load_x   = 1'b0;
      cmd.mul_sel  = MUL_A1_IC1;
      cmd.acc_op   = ACC_HOLD;
      cmd.cap_v1   = 1'b0;
      cmd.upd_int  = 1'b0;
      cmd.load_out = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_x = 1'b1;
               state_in   = ST_PROD_A1;
            end
         end
         ST_PROD_A1: begin
            cmd.mul_sel = MUL_A1_IC1;
            state_in    = ST_PROD_A2V3;
         end
         ST_PROD_A2V3: begin
            cmd.mul_sel = MUL_A2_V3;
            cmd.acc_op  = ACC_LOAD;
            state_in    = ST_PROD_A2IC1;
         end
         ST_PROD_A2IC1: begin
            cmd.mul_sel = MUL_A2_IC1;
            cmd.acc_op  = ACC_ADD;
            state_in    = ST_PROD_A3V3;
         end
         ST_PROD_A3V3: begin
            // accumulator now holds the v1 sum
            cmd.mul_sel = MUL_A3_V3;
            cmd.cap_v1  = 1'b1;
            cmd.acc_op  = ACC_LOAD;
            state_in    = ST_PROD_KV1;
         end
         ST_PROD_KV1: begin
            cmd.mul_sel = MUL_K_V1;
            cmd.acc_op  = ACC_ADD;
            state_in    = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.upd_int = 1'b1;
            cmd.acc_op  = ACC_LOAD;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the output register can take the beat
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

/* design/svf_datapath.sv */
// Datapath: shared multiplier, accumulator, integrators and output register.
`timescale 1ns / 1ps
module svf_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  svf_pkg::cfg_type              cfg,
   input  svf_pkg::cmd_type              cmd,
   output svf_pkg::status_type           status,
   input  logic [svf_pkg::SAMPLE_W-1:0]  req_sample_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [svf_pkg::SAMPLE_W-1:0]  rsp_sample_out
);
   import svf_pkg::*;

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC - 1);

   logic        [SAMPLE_W-1:0] x_ff, x_in;
   logic        [WIDE_W-1:0]   v3_ff, v3_in;
   logic        [WIDE_W-1:0]   v1_ff, v1_in;
   logic        [WIDE_W-1:0]   v2_ff, v2_in;
   logic        [INT_W-1:0]    ic1_ff, ic1_in;
   logic        [INT_W-1:0]    ic2_ff, ic2_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic        [SAMPLE_W-1:0] out_ff, out_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic        [COEF_W-1:0]   coef_sel;
   logic signed [OPA_W-1:0]    opa;
   logic signed [WIDE_W-1:0]   opb;
   logic signed [ACC_W-1:0]    prod_ext;
   logic signed [ACC_W-1:0]    rnd_full;
   logic        [WIDE_W-1:0]   rnd;
   logic        [WIDE_W-1:0]   ic1_w, ic2_w, x_w;
   logic        [SUM_W-1:0]    ic1_s, ic2_s, x_s, v1_s, v2_s, v2n_s, kv1_s;
   logic        [SUM_W-1:0]    upd1, upd2, y_s;

   assign ic1_w = {{(WIDE_W-INT_W){ic1_ff[INT_W-1]}}, ic1_ff};
   assign ic2_w = {{(WIDE_W-INT_W){ic2_ff[INT_W-1]}}, ic2_ff};
   assign x_w   = {{(WIDE_W-SAMPLE_W){req_sample_in[SAMPLE_W-1]}}, req_sample_in};

   // operand selection for the shared multiplier
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_A1_IC1: begin coef_sel = cfg.coef_a1; opb = ic1_w; end
         MUL_A2_V3:  begin coef_sel = cfg.coef_a2; opb = v3_ff; end
         MUL_A2_IC1: begin coef_sel = cfg.coef_a2; opb = ic1_w; end
         MUL_A3_V3:  begin coef_sel = cfg.coef_a3; opb = v3_ff; end
         MUL_K_V1:   begin coef_sel = cfg.damping; opb = v1_ff; end
         default:    begin coef_sel = cfg.coef_a1; opb = ic1_w; end
      endcase
   end

   assign opa      = {1'b0, coef_sel};
   assign prod_in  = opa * opb;
   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   always_comb begin
      unique case (cmd.acc_op)
         ACC_HOLD: acc_in = acc_ff;
         ACC_LOAD: acc_in = prod_ext;
         ACC_ADD:  acc_in = acc_ff + prod_ext;
         default:  acc_in = acc_ff;
      endcase
   end

   // round to nearest, ties upward, back to the sample scale
   assign rnd_full = (acc_ff + ROUND_HALF) >>> COEF_FRAC;
   assign rnd      = rnd_full[WIDE_W-1:0];

   assign ic1_s = {{(SUM_W-INT_W){ic1_ff[INT_W-1]}}, ic1_ff};
   assign ic2_s = {{(SUM_W-INT_W){ic2_ff[INT_W-1]}}, ic2_ff};
   assign x_s   = {{(SUM_W-SAMPLE_W){x_ff[SAMPLE_W-1]}}, x_ff};
   assign v1_s  = {{(SUM_W-WIDE_W){v1_ff[WIDE_W-1]}}, v1_ff};
   assign v2_s  = {{(SUM_W-WIDE_W){v2_ff[WIDE_W-1]}}, v2_ff};
   assign kv1_s = {{(SUM_W-WIDE_W){rnd[WIDE_W-1]}}, rnd};

   assign v2n_s = ic2_s + {{(SUM_W-WIDE_W){rnd[WIDE_W-1]}}, rnd};
   assign upd1  = (v1_s << 1) - ic1_s;
   assign upd2  = (v2n_s << 1) - ic2_s;

   always_comb begin
      x_in   = x_ff;
      v3_in  = v3_ff;
      v1_in  = v1_ff;
      v2_in  = v2_ff;
      ic1_in = ic1_ff;
      ic2_in = ic2_ff;
      if (cmd.load_x) begin
         x_in  = req_sample_in;
         v3_in = x_w - ic2_w;
      end
      if (cmd.cap_v1) begin
         v1_in = rnd;
      end
      if (cmd.upd_int) begin
         v2_in  = v2n_s[WIDE_W-1:0];
         ic1_in = sat_int(upd1);
         ic2_in = sat_int(upd2);
      end
   end

   // response selection; accumulator holds k*v1 here
   always_comb begin
      unique case (cfg.mode)
         MODE_LOWPASS:  y_s = v2_s;
         MODE_BANDPASS: y_s = v1_s;
         MODE_HIGHPASS: y_s = x_s - kv1_s - v2_s;
         MODE_NOTCH:    y_s = x_s - kv1_s;
         MODE_PEAK:     y_s = x_s - kv1_s - (v2_s << 1);
         default:       y_s = '0;
      endcase
   end

   assign out_in       = cmd.load_out ? sat_sample(y_s) : out_ff;
   assign rsp_valid_in = cmd.load_out | (rsp_valid_ff & ~rsp_ready);

   assign status.out_free = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_out  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ic1_ff       <= '0;
         ic2_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ic1_ff       <= ic1_in;
         ic2_ff       <= ic2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      v3_ff   <= v3_in;
      v1_ff   <= v1_in;
      v2_ff   <= v2_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      out_ff  <= out_in;
   end

endmodule
